// ===== src/band_mean_amplitude_meter_core_defines.svh =====
// Assertion helpers for the level meter. Clock clk_i and reset rst_ni are
// taken from the scope that uses them.
`ifndef BAND_MEAN_AMPLITUDE_METER_CORE_DEFINES_SVH
`define BAND_MEAN_AMPLITUDE_METER_CORE_DEFINES_SVH

// same-cycle implication
`define BMAM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bmam_pkg.sv =====
`default_nettype none

package bmam_pkg;

  // buffer geometry
  localparam int unsigned SAMPLES_PER_BUFFER = 512;
  localparam int unsigned BAND_COUNT         = 16;
  localparam int unsigned BAND_LEN           = SAMPLES_PER_BUFFER / BAND_COUNT;

  // fixed field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FS_W       = 16;
  localparam int unsigned HEIGHT_W   = 8;
  localparam int unsigned BAND_NUM_W = 6;
  localparam int unsigned SUM_W      = 28;
  localparam int unsigned MEAN_W     = 16;
  localparam int unsigned PROD_W     = MEAN_W + HEIGHT_W;
  localparam int unsigned DIVISOR_W  = 16;

  // derived counter widths
  localparam int unsigned BUF_POS_W  = $clog2(SAMPLES_PER_BUFFER);
  localparam int unsigned BAND_POS_W = (BAND_LEN > 2) ? $clog2(BAND_LEN) : 1;
  localparam int unsigned BAND_W     = $clog2(BAND_COUNT + 1);

  // mean by reciprocal multiplication: exact floor for any SUM_W-bit sum
  localparam int unsigned BAND_LEN_NZ = (BAND_LEN == 0) ? 1 : BAND_LEN;
  localparam int unsigned MEAN_SHIFT  = SUM_W + $clog2(BAND_LEN_NZ);
  localparam int unsigned RECIP_W     = SUM_W + 1;
  localparam int unsigned MEAN_PROD_W = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] MEAN_RECIP =
    RECIP_W'(((64'd1 << MEAN_SHIFT) + 64'(BAND_LEN_NZ) - 64'd1) / 64'(BAND_LEN_NZ));

  // divider: one quotient bit per step
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_SCALE = 1'b0,
    CFG_HEIGHT     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                 start;
    logic [SUM_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

// ===== src/bmam_in_if.sv =====
`default_nettype none

interface bmam_in_if;
  import bmam_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;

  modport source (output valid, output left_sample, input ready);
  modport sink   (input valid, input left_sample, output ready);
endinterface

`default_nettype wire

// ===== src/bmam_out_if.sv =====
`default_nettype none

interface bmam_out_if;
  import bmam_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [BAND_NUM_W-1:0] band_number;
  logic [HEIGHT_W-1:0]   bar_level;
  logic                  last_band;

  modport source (output valid, output band_number, output bar_level, output last_band,
                  input ready);
  modport sink   (input valid, input band_number, input bar_level, input last_band,
                  output ready);
endinterface

`default_nettype wire

// ===== src/bmam_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. done_o pulses once the
// quotient is final.
module bmam_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bmam_pkg::div_req_t          req_i,
  output logic                        done_o,
  output logic [bmam_pkg::SUM_W-1:0]  quot_o
);
  import bmam_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0]     quot_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [DIVISOR_W-1:0] divisor_q;

  logic [DIVISOR_W:0]   rem_sh;
  logic                 fits;
  logic [DIVISOR_W:0]   rem_nx;

  assign rem_sh = {rem_q, quot_q[SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor_q};
  assign rem_nx = fits ? (rem_sh - {1'b0, divisor_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q    <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      quot_q <= {quot_q[SUM_W-2:0], fits};
      rem_q  <= rem_nx[DIVISOR_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== src/band_mean_amplitude_meter_core.sv =====
// A word that does not close a band is absorbed in its accept cycle.
// A word that closes a band gives its result through the sequencer: a
// reciprocal multiply for the mean, a step to launch the divide, the divider
// steps, a clamp and a load of the output register.
// Throughput: one word per cycle inside a band; the closing word holds ready
// low until its result is in the output register, longer while it is full.
// Reset (async, active low) clears counters, sequencer and output valid, and
// loads full scale 32768, height 64.
`default_nettype none

module band_mean_amplitude_meter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bmam_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bmam_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bmam_in_if.sink                         in_i,
  bmam_out_if.source                      out_o
);
  import bmam_pkg::*;

  `include "band_mean_amplitude_meter_core_defines.svh"

  // Sequencer: IDLE takes words; MEAN forms the mean by reciprocal multiply,
  // MUL scales it and launches the divide, DIV divides by full scale,
  // OUT hands over.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MEAN = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [FS_W-1:0]       fs_q;
  logic [HEIGHT_W-1:0]   height_q;
  logic [DIVISOR_W-1:0]  fs_eff;

  // band tracking
  logic [SUM_W-1:0]      band_sum_q;
  logic [BAND_POS_W-1:0] pos_band_q;
  logic [BAND_W-1:0]     cur_band_q;
  logic [BUF_POS_W-1:0]  pos_buf_q;

  // band result in flight
  logic [BAND_NUM_W-1:0] rep_band_q;
  logic                  rep_last_q;
  logic [SUM_W-1:0]      fin_sum_q;
  logic [MEAN_W-1:0]     mean_q;
  logic [HEIGHT_W-1:0]   level_q;

  // output register
  logic                  out_valid_q;
  logic [BAND_NUM_W-1:0] out_band_q;
  logic [HEIGHT_W-1:0]   out_level_q;
  logic                  out_last_q;

  logic                   accept;
  logic [SAMPLE_W-1:0]    raw;
  logic [SAMPLE_W-1:0]    mag;
  logic [SUM_W-1:0]       sum_nx;
  logic                   band_active;
  logic                   band_end;
  logic                   buf_end;
  logic                   slot_free;
  logic [MEAN_PROD_W-1:0] mean_prod;
  logic [PROD_W-1:0]      scaled;

  div_req_t              div_req;
  logic                  div_done;
  logic [SUM_W-1:0]      div_quot;

  // ---------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q     <= FS_W'(32768);
      height_q <= HEIGHT_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FULL_SCALE: fs_q     <= cfg_data_i[FS_W-1:0];
        CFG_HEIGHT:     height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // full scale of zero behaves as one
  assign fs_eff = (fs_q == '0) ? DIVISOR_W'(1) : DIVISOR_W'(fs_q);

  // ---------------------------------------------------------------------
  // Word intake: magnitude and accumulate in the accept cycle
  // ---------------------------------------------------------------------
  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // most negative sample wraps to 0x8000, which is its magnitude
  assign raw    = in_i.left_sample;
  assign mag    = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
  assign sum_nx = band_sum_q + SUM_W'(mag);

  // bands of zero size never report; leftover words past the last band
  // only advance the buffer position
  assign band_active = (BAND_LEN != 0) && (cur_band_q < BAND_W'(BAND_COUNT));
  assign band_end    = band_active && (pos_band_q == BAND_POS_W'(BAND_LEN - 1));
  assign buf_end     = (pos_buf_q == BUF_POS_W'(SAMPLES_PER_BUFFER - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_sum_q <= '0;
      pos_band_q <= '0;
      cur_band_q <= '0;
      pos_buf_q  <= '0;
    end else if (accept) begin
      if (band_active) begin
        if (band_end) begin
          band_sum_q <= '0;
          pos_band_q <= '0;
          cur_band_q <= cur_band_q + 1'b1;
        end else begin
          band_sum_q <= sum_nx;
          pos_band_q <= pos_band_q + 1'b1;
        end
      end
      if (buf_end) begin
        pos_buf_q  <= '0;
        band_sum_q <= '0;
        pos_band_q <= '0;
        cur_band_q <= '0;
      end else begin
        pos_buf_q <= pos_buf_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Mean: sum times rounded-up reciprocal of the band length, then shift
  // ---------------------------------------------------------------------
  assign mean_prod = MEAN_PROD_W'(fin_sum_q) * MEAN_PROD_W'(MEAN_RECIP);

  // mean is at most 32768, so the scaled value fits PROD_W bits
  assign scaled = PROD_W'(mean_q) * PROD_W'(height_q);

  // ---------------------------------------------------------------------
  // Divider: scaled mean / full scale
  // ---------------------------------------------------------------------
  always_comb begin
    div_req.start    = (state_q == S_MUL);
    div_req.dividend = SUM_W'(scaled);
    div_req.divisor  = fs_eff;
  end

  bmam_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign slot_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept && band_end) state_d = S_MEAN;
      S_MEAN:  state_d = S_MUL;
      S_MUL:   state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_OUT;
      S_OUT:   if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // band payload and arithmetic results
  always_ff @(posedge clk_i) begin
    if (accept && band_end) begin
      rep_band_q <= BAND_NUM_W'(cur_band_q);
      rep_last_q <= (cur_band_q == BAND_W'(BAND_COUNT - 1));
      fin_sum_q  <= sum_nx;
    end
    if (state_q == S_MEAN) begin
      mean_q <= mean_prod[MEAN_SHIFT +: MEAN_W];
    end
    // clamp to the display height
    if (state_q == S_DIV && div_done) begin
      level_q <= (div_quot > SUM_W'(height_q)) ? height_q : div_quot[HEIGHT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && slot_free) begin
      out_band_q  <= rep_band_q;
      out_level_q <= level_q;
      out_last_q  <= rep_last_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.band_number = out_band_q;
  assign out_o.bar_level   = out_level_q;
  assign out_o.last_band   = out_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `BMAM_ASSERT_NOW(a_level_clamped, out_o.valid, out_o.bar_level <= height_q, "level over height")
  `BMAM_ASSERT_NOW(a_band_in_range, out_o.valid, {1'b0, out_o.band_number} < (BAND_NUM_W+1)'(BAND_COUNT), "band out of range")
  `BMAM_ASSERT_NEXT(a_band_end_starts, accept && band_end, state_q == S_MEAN, "band end not taken")
  `BMAM_ASSERT_NOW(a_no_done_idle, state_q == S_IDLE, !div_done, "divider finished while idle")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bmam_pkg::*;

  // no word accepted on either side for this many cycles ends the run
  localparam int unsigned STALL_LIMIT = 6000;
  // margin before a register write once every expected word is out
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned RANDOM_WORDS = 1400;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [BAND_NUM_W-1:0] band_number;
    logic [HEIGHT_W-1:0]   bar_level;
    logic                  last_band;
  } bar_t;

  // how a directed row fills its band
  typedef enum logic [1:0] {
    FILL_CONST = 2'd0,
    FILL_ALT   = 2'd1,
    FILL_RAND  = 2'd2
  } fill_e;

  // one directed row = one full band of samples
  typedef struct packed {
    logic                do_cfg;
    logic [FS_W-1:0]     fs;
    logic [HEIGHT_W-1:0] height;
    fill_e               fill;
    logic [SAMPLE_W-1:0] value;
    logic                typed;
    logic [HEIGHT_W-1:0] level;
  } band_row_t;

  localparam int unsigned N_ROWS = 12;

  // rows 0..11 are bands 0..11 of the first buffer after reset
  band_row_t band_rows [0:N_ROWS-1] = '{
    // reset scaling, most negative sample: 32768 * 64 / 32768
    '{1'b0, 16'd0,     8'd0,   FILL_CONST, 16'h8000, 1'b1, 8'd64},
    '{1'b0, 16'd0,     8'd0,   FILL_CONST, 16'h7fff, 1'b1, 8'd63},
    '{1'b0, 16'd0,     8'd0,   FILL_CONST, 16'h0000, 1'b1, 8'd0},
    '{1'b0, 16'd0,     8'd0,   FILL_ALT,   16'd1000, 1'b0, 8'd0},
    // zero full scale behaves as one; level reaches height
    '{1'b1, 16'd0,     8'd255, FILL_CONST, 16'h0001, 1'b1, 8'd255},
    // zero height gives nothing but zero
    '{1'b1, 16'd1,     8'd0,   FILL_CONST, 16'h8000, 1'b1, 8'd0},
    '{1'b1, 16'hffff,  8'd255, FILL_CONST, 16'h8000, 1'b1, 8'd127},
    '{1'b1, 16'h8000,  8'd1,   FILL_CONST, 16'h7fff, 1'b1, 8'd0},
    '{1'b0, 16'd0,     8'd0,   FILL_CONST, 16'h8000, 1'b1, 8'd1},
    '{1'b1, 16'd100,   8'd200, FILL_ALT,   16'd50,   1'b1, 8'd100},
    '{1'b1, 16'd16384, 8'd64,  FILL_RAND,  16'h0000, 1'b0, 8'd0},
    '{1'b0, 16'd0,     8'd0,   FILL_RAND,  16'h0000, 1'b0, 8'd0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  bmam_in_if  in_if ();
  bmam_out_if out_if ();

  band_mean_amplitude_meter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // predictor copy of the registers and of the band accumulator
  logic [FS_W-1:0]     fs_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [SUM_W-1:0]    abs_sum;
  logic [11:0]         band_fill;
  logic [6:0]          band_idx;
  logic [11:0]         buf_fill;

  bar_t expected_bars [$];
  int   error_count;
  int   bars_seen;
  bit   calm;        // no random gaps on either side while set; hold-offs still apply

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: absolute value, band sum, truncated mean, scale and clamp
  // ---------------------------------------------------------------------------
  function automatic bit track_sample(input logic [SAMPLE_W-1:0] s, output bar_t bar);
    logic [16:0]   mag;
    logic [SUM_W-1:0] mean;
    logic [63:0]   lvl;
    logic [16:0]   fs_eff;
    bit            got;
    got = 1'b0;
    bar = '0;
    // most negative word has magnitude 32768
    mag = s[15] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
    if (BAND_LEN > 0 && band_idx < BAND_COUNT) begin
      abs_sum   = abs_sum + SUM_W'(mag);
      band_fill = band_fill + 12'd1;
      if (band_fill >= BAND_LEN) begin
        mean   = SUM_W'(abs_sum / BAND_LEN);
        fs_eff = (fs_reg == '0) ? 17'd1 : {1'b0, fs_reg};
        lvl    = (64'(mean) * 64'(height_reg)) / 64'(fs_eff);
        if (lvl > 64'(height_reg)) lvl = 64'(height_reg);
        bar.band_number = band_idx[BAND_NUM_W-1:0];
        bar.bar_level   = lvl[HEIGHT_W-1:0];
        bar.last_band   = (band_idx == BAND_COUNT - 1);
        got       = 1'b1;
        abs_sum   = '0;
        band_fill = '0;
        band_idx  = band_idx + 7'd1;
      end
    end
    // leftover samples past the last band only move the buffer position
    buf_fill = buf_fill + 12'd1;
    if (buf_fill >= SAMPLES_PER_BUFFER) begin
      buf_fill  = '0;
      band_idx  = '0;
      abs_sum   = '0;
      band_fill = '0;
    end
    return got;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm)    return 0;
    if (r < 55)  return 0;
    if (r < 85)  return $urandom_range(1, 3);
    if (r < 97)  return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned cap);
    int          r;
    int unsigned mag;
    logic [SAMPLE_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      v = SAMPLE_W'($urandom());
    end else if (r < 85) begin
      mag = $urandom_range(0, cap);
      if ($urandom_range(0, 1)) v = SAMPLE_W'(-int'(mag));
      else                      v = (mag > 32767) ? 16'h7fff : SAMPLE_W'(mag);
    end else begin
      case ($urandom_range(0, 3))
        0:       v = 16'h8000;
        1:       v = 16'h7fff;
        2:       v = 16'h0000;
        default: v = 16'hffff;
      endcase
    end
    return v;
  endfunction

  // offer one word, hold it until the block takes it
  task automatic offer_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.left_sample <= s;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
  endtask

  task automatic feed_sample(input logic [SAMPLE_W-1:0] s);
    bar_t bar;
    offer_sample(s);
    if (track_sample(s, bar)) expected_bars.push_back(bar);
  endtask

  // input quiet, every expected word out, then a short margin
  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_bars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // writes each requested register in turn; enable dropped once at the end
  task automatic set_config(input bit do_fs, input logic [FS_W-1:0] fs,
                            input bit do_h, input logic [CFG_DATA_W-1:0] h_data);
    if (do_fs) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_FULL_SCALE;
      cfg_data <= fs;
      @(posedge clk_i);
      fs_reg = fs;
    end
    if (do_h) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_HEIGHT;
      cfg_data <= h_data;
      @(posedge clk_i);
      height_reg = h_data[HEIGHT_W-1:0];
    end
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, long hold-offs, compare against oldest expectation
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int   stall_left;
    int   hold_left;
    bit   hold_a_done;
    bit   hold_b_done;
    bit   nxt;
    bar_t want;
    stall_left  = 0;
    hold_left   = 0;
    hold_a_done = 1'b0;
    hold_b_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        bars_seen++;
        if (expected_bars.size() == 0) begin
          $error("unexpected result word: band_number %0d bar_level %0d last_band %0d",
                 out_if.band_number, out_if.bar_level, out_if.last_band);
          error_count++;
        end else begin
          want = expected_bars.pop_front();
          if (out_if.band_number !== want.band_number) begin
            $error("band_number: expected %0d, got %0d", want.band_number,
                   out_if.band_number);
            error_count++;
          end
          if (out_if.bar_level !== want.bar_level) begin
            $error("bar_level: expected %0d, got %0d", want.bar_level, out_if.bar_level);
            error_count++;
          end
          if (out_if.last_band !== want.last_band) begin
            $error("last_band: expected %0d, got %0d", want.last_band, out_if.last_band);
            error_count++;
          end
        end
      end
      // long hold-off while the sender keeps offering: block must back up
      if (hold_left == 0 && in_if.valid &&
          ((!hold_a_done && bars_seen >= 20) || (!hold_b_done && bars_seen >= 45))) begin
        if (!hold_a_done) hold_a_done = 1'b1;
        else              hold_b_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        nxt = 1'b0;
      end else begin
        nxt = 1'b1;
      end
      out_if.ready <= nxt;
    end
  end

  // watchdog: cycles with no word moving on either side
  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle = 0;
      else
        idle++;
      if (idle >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed band table, then random phases with config changes
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    bar_t        bar;
    band_row_t   row;
    logic [SAMPLE_W-1:0] s;
    int unsigned sent;
    int unsigned n;
    int unsigned cap;
    logic [FS_W-1:0] fs;
    logic [HEIGHT_W-1:0] h;
    bit          do_fs;
    bit          do_h;

    error_count = 0;
    bars_seen   = 0;
    calm        = 1'b0;
    fs_reg      = 16'h8000;
    height_reg  = 8'd64;
    abs_sum     = '0;
    band_fill   = '0;
    band_idx    = '0;
    buf_fill    = '0;

    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_FULL_SCALE;
    cfg_data          <= '0;
    in_if.valid       <= 1'b0;
    in_if.left_sample <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: each row fills one band; typed rows carry the level by hand
    for (int r = 0; r < N_ROWS; r++) begin
      row = band_rows[r];
      if (row.do_cfg) begin
        settle();
        set_config(1'b1, row.fs, 1'b1, {8'($urandom()), row.height});
      end
      for (int k = 0; k < BAND_LEN; k++) begin
        case (row.fill)
          FILL_ALT:  s = k[0] ? SAMPLE_W'(-int'(row.value)) : row.value;
          FILL_RAND: s = SAMPLE_W'($urandom());
          default:   s = row.value;
        endcase
        offer_sample(s);
        if (track_sample(s, bar)) begin
          if (row.typed) begin
            bar.band_number = BAND_NUM_W'(r);
            bar.bar_level   = row.level;
            bar.last_band   = 1'b0;
          end
          expected_bars.push_back(bar);
        end
      end
    end

    // random phases: new scaling at idle points, bursts not tied to bands
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      settle();
      calm = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 3))
        0:       cap = 32768;
        1:       cap = $urandom_range(0, 255);
        2:       cap = $urandom_range(256, 4095);
        default: cap = $urandom_range(4096, 32768);
      endcase
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0:       fs = 16'h0000;
            1:       fs = 16'h0001;
            2:       fs = 16'hffff;
            default: fs = 16'h8000;
          endcase
        end
        1, 2, 3, 4: fs = FS_W'($urandom_range(1, 65535));
        default:    fs = FS_W'($urandom_range(cap / 4 + 1,
                                              (cap * 2 > 65535) ? 65535 : cap * 2 + 1));
      endcase
      if ($urandom_range(0, 6) == 0) begin
        case ($urandom_range(0, 2))
          0:       h = 8'd0;
          1:       h = 8'd1;
          default: h = 8'd255;
        endcase
      end else begin
        h = HEIGHT_W'($urandom_range(1, 255));
      end
      do_fs = ($urandom_range(0, 9) < 7);
      do_h  = ($urandom_range(0, 9) < 7);
      if (do_fs || do_h) set_config(do_fs, fs, do_h, {8'($urandom()), h});
      n = $urandom_range(60, 260);
      for (int k = 0; k < n; k++) feed_sample(pick_sample(cap));
      sent += n;
    end
    calm = 1'b0;

    settle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
